// File: rtl/core/skf_pkg.sv
// Shared types, constants and the sequencer microprogram of the scalar Kalman filter.
// Used by skf_datapath, scalar_kalman_filter_top and skf_checker; no dependencies.
`timescale 1ns / 1ps

package skf_pkg;

  // Default geometry of the Q format
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Gain is unsigned Q1.16 regardless of data format
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  // Division loop counter
  localparam int LOOP_CNT_W = $clog2(GAIN_FRAC);
  localparam logic [LOOP_CNT_W-1:0] DIV_LOOP_LAST = LOOP_CNT_W'(GAIN_FRAC - 1);

  // Configuration register index
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE = 2'd0,
    REG_MEAS_NOISE    = 2'd1,
    REG_INIT_EST      = 2'd2
  } cfg_reg_t;

  // Datapath operations, one per microinstruction
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_GROW,
    OP_DENOM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN_FIX,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_SUM,
    OP_EST,
    OP_MUL_COV,
    OP_COV
  } dp_op_t;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_LOOP,
    C_WAIT_OUT,
    C_JUMP
  } seq_cond_t;

  // Program counter and step addresses
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_WAIT     = 4'd0;
  localparam pc_t STEP_GROW     = 4'd1;
  localparam pc_t STEP_DENOM    = 4'd2;
  localparam pc_t STEP_DIV_INIT = 4'd3;
  localparam pc_t STEP_DIV_LOOP = 4'd4;
  localparam pc_t STEP_GAIN_FIX = 4'd5;
  localparam pc_t STEP_MUL_HI   = 4'd6;
  localparam pc_t STEP_MUL_LO   = 4'd7;
  localparam pc_t STEP_SUM      = 4'd8;
  localparam pc_t STEP_EST      = 4'd9;
  localparam pc_t STEP_MUL_COV  = 4'd10;
  localparam pc_t STEP_COV      = 4'd11;
  localparam pc_t STEP_EMIT     = 4'd12;

  // One microinstruction
  typedef struct packed {
    dp_op_t    op;
    seq_cond_t cond;
    logic      cnt_load;
    pc_t       target;
  } ucode_t;

  // Control bundle from sequencer to datapath
  typedef struct packed {
    dp_op_t op;
    logic   restart;
  } dp_ctrl_t;

  // Microprogram ROM
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_JUMP, cnt_load: 1'b0, target: STEP_WAIT};
    unique case (pc)
      STEP_WAIT:     w = '{OP_LOAD,     C_WAIT_IN,  1'b0, STEP_WAIT};
      STEP_GROW:     w = '{OP_GROW,     C_NEXT,     1'b0, STEP_WAIT};
      STEP_DENOM:    w = '{OP_DENOM,    C_NEXT,     1'b0, STEP_WAIT};
      STEP_DIV_INIT: w = '{OP_DIV_INIT, C_NEXT,     1'b1, STEP_WAIT};
      STEP_DIV_LOOP: w = '{OP_DIV_STEP, C_LOOP,     1'b0, STEP_DIV_LOOP};
      STEP_GAIN_FIX: w = '{OP_GAIN_FIX, C_NEXT,     1'b0, STEP_WAIT};
      STEP_MUL_HI:   w = '{OP_MUL_HI,   C_NEXT,     1'b0, STEP_WAIT};
      STEP_MUL_LO:   w = '{OP_MUL_LO,   C_NEXT,     1'b0, STEP_WAIT};
      STEP_SUM:      w = '{OP_SUM,      C_NEXT,     1'b0, STEP_WAIT};
      STEP_EST:      w = '{OP_EST,      C_NEXT,     1'b0, STEP_WAIT};
      STEP_MUL_COV:  w = '{OP_MUL_COV,  C_NEXT,     1'b0, STEP_WAIT};
      STEP_COV:      w = '{OP_COV,      C_NEXT,     1'b0, STEP_WAIT};
      STEP_EMIT:     w = '{OP_NOP,      C_WAIT_OUT, 1'b0, STEP_WAIT};
      default:       w = '{OP_NOP,      C_JUMP,     1'b0, STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/skf_datapath.sv
// Arithmetic datapath of the scalar Kalman filter: state, divider, shared multiplier.
// Driven one operation per cycle by the microsequencer; depends on skf_pkg.
`timescale 1ns / 1ps

module skf_datapath #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  skf_pkg::dp_ctrl_t                 ctrl,
  input  logic signed [DATA_WIDTH-1:0]      measurement,
  input  logic        [DATA_WIDTH-1:0]      process_noise,
  input  logic        [DATA_WIDTH-1:0]      measurement_noise,
  input  logic signed [DATA_WIDTH-1:0]      initial_estimate,
  output logic signed [DATA_WIDTH-1:0]      est_value,
  output logic        [skf_pkg::GAIN_W-1:0] gain
);

  localparam int W  = DATA_WIDTH;
  localparam int GW = skf_pkg::GAIN_W;
  localparam int GF = skf_pkg::GAIN_FRAC;
  localparam int PW = W + GW;

  localparam logic [63:0]   ONE_WIDE = 64'd1 << FRAC_BITS;
  localparam logic [W-1:0]  VAL_ONE  = ONE_WIDE[W-1:0];
  localparam logic [PW-1:0] RND_HALF = PW'(1) << (GF - 1);

  // Filter state
  logic [W-1:0]    est;
  logic [W-1:0]    cov;

  // Working registers
  logic [W-1:0]    meas;
  logic [W-1:0]    p;
  logic [W:0]      denom;
  logic [W:0]      mag;
  logic            neg;
  logic [W+1:0]    rem;
  logic [GW-1:0]   quo;
  logic [PW-1:0]   prod;
  logic [W+1:0]    delta;

  // Combinational terms
  logic [W:0]      cov_sum;
  logic [W:0]      res;
  logic [W:0]      res_mag;
  logic [W+1:0]    div_in;
  logic [W+1:0]    div_den;
  logic            div_ge;
  logic [W+1:0]    div_diff;
  logic [W:0]      mag_hi;
  logic [W-1:0]    mul_a;
  logic [GW-1:0]   mul_b;
  logic [PW-1:0]   mul_p;
  logic [PW-1:0]   prod_rnd;
  logic [W+2:0]    est_ext;
  logic [W+2:0]    delta_ext;
  logic [W+2:0]    est_new;
  logic            est_ovf;
  logic [W-1:0]    est_sat;

  // Covariance growth with saturation
  assign cov_sum = {1'b0, cov} + {1'b0, process_noise};

  // Residual and its magnitude
  assign res     = {meas[W-1], meas} - {est[W-1], est};
  assign res_mag = res[W] ? (~res + (W+1)'(1)) : res;

  // Restoring divider step: first compare is unshifted, the rest shift by one
  assign div_in   = (ctrl.op == skf_pkg::OP_DIV_INIT) ? {2'b00, p} : {rem[W:0], 1'b0};
  assign div_den  = {1'b0, denom};
  assign div_ge   = (div_in >= div_den);
  assign div_diff = div_in - div_den;

  // Shared multiplier operand select
  assign mag_hi = mag >> GF;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.op)
      skf_pkg::OP_MUL_HI: begin
        mul_a = mag_hi[W-1:0];
        mul_b = quo;
      end
      skf_pkg::OP_MUL_LO: begin
        mul_a = W'(mag[GF-1:0]);
        mul_b = quo;
      end
      skf_pkg::OP_MUL_COV: begin
        mul_a = p;
        mul_b = skf_pkg::GAIN_ONE - quo;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = {{GW{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  // Round half up of the registered product
  assign prod_rnd = prod + RND_HALF;

  // Estimate update with saturation to the signed range
  assign est_ext   = {{3{est[W-1]}}, est};
  assign delta_ext = {1'b0, delta};
  assign est_new   = neg ? (est_ext - delta_ext) : (est_ext + delta_ext);
  assign est_ovf   = !((&est_new[W+2:W-1]) || (~|est_new[W+2:W-1]));
  assign est_sat   = {est_new[W+2], {(W-1){~est_new[W+2]}}};

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      cov <= VAL_ONE;
    end else if (ctrl.restart) begin
      est <= initial_estimate;
      cov <= VAL_ONE;
    end else begin
      if (ctrl.op == skf_pkg::OP_EST) begin
        est <= est_ovf ? est_sat : est_new[W-1:0];
      end
      if (ctrl.op == skf_pkg::OP_COV) begin
        cov <= prod_rnd[W+GF-1:GF];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      skf_pkg::OP_LOAD: meas <= measurement;
      skf_pkg::OP_GROW: p <= cov_sum[W] ? {W{1'b1}} : cov_sum[W-1:0];
      skf_pkg::OP_DENOM: begin
        denom <= {1'b0, p} + {1'b0, measurement_noise};
        neg   <= res[W];
        mag   <= res_mag;
      end
      skf_pkg::OP_DIV_INIT,
      skf_pkg::OP_DIV_STEP: begin
        rem <= div_ge ? div_diff : div_in;
        quo <= {quo[GW-2:0], div_ge} & {GW{ctrl.op == skf_pkg::OP_DIV_STEP}}
             | {{(GW-1){1'b0}}, div_ge};
      end
      skf_pkg::OP_GAIN_FIX: if (denom == '0) quo <= '0;
      skf_pkg::OP_MUL_HI: prod <= mul_p;
      skf_pkg::OP_MUL_LO: begin
        delta <= prod[W+1:0];
        prod  <= mul_p;
      end
      skf_pkg::OP_SUM: delta <= delta + {1'b0, prod_rnd[PW-1:GF]};
      skf_pkg::OP_MUL_COV: prod <= mul_p;
      default: ;
    endcase
  end

  assign est_value = est;
  assign gain      = quo;

endmodule

// File: rtl/core/scalar_kalman_filter_top.sv
// One measurement at a time: a new one is taken only after the previous result has gone
// through the restoring division for the gain and into the output register.
// Output register lets a result wait while the next measurement is taken.
// Reset: Q = 0.1, R = 1.0, estimate 0, covariance 1.0; an initial_estimate write
// restarts the filter. Depends on skf_pkg and skf_datapath.
`timescale 1ns / 1ps

module scalar_kalman_filter_top #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // measurement channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [DATA_WIDTH-1:0]      measurement,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]      filtered_value,
  output logic        [skf_pkg::GAIN_W-1:0] gain_used,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_WIDTH-1:0]             cfg_data
);

  localparam int W = DATA_WIDTH;

  localparam logic [63:0]  ONE_WIDE  = 64'd1 << FRAC_BITS;
  localparam logic [63:0]  Q_WIDE    = (ONE_WIDE + 64'd5) / 64'd10;
  localparam logic [W-1:0] VAL_ONE   = ONE_WIDE[W-1:0];
  localparam logic [W-1:0] Q_RESET   = Q_WIDE[W-1:0];

  // Configuration registers
  logic [W-1:0]        process_noise;
  logic [W-1:0]        measurement_noise;

  // Sequencer
  skf_pkg::pc_t                      pc;
  skf_pkg::pc_t                      pc_next;
  skf_pkg::ucode_t                   uword;
  logic [skf_pkg::LOOP_CNT_W-1:0]    cnt;
  logic                              in_fire;
  logic                              cfg_fire;
  logic                              out_load;
  skf_pkg::dp_ctrl_t                 ctrl;

  // Datapath results
  logic signed [W-1:0]               est_value;
  logic [skf_pkg::GAIN_W-1:0]        gain;

  assign uword     = skf_pkg::ucode_rom(pc);
  assign cfg_ready = (pc == skf_pkg::STEP_WAIT);
  assign in_ready  = (pc == skf_pkg::STEP_WAIT) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_load  = (uword.cond == skf_pkg::C_WAIT_OUT) && (!out_valid || out_ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= Q_RESET;
      measurement_noise <= VAL_ONE;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        skf_pkg::REG_PROCESS_NOISE: process_noise     <= cfg_data;
        skf_pkg::REG_MEAS_NOISE:    measurement_noise <= cfg_data;
        // write data goes straight into the estimate on restart
        skf_pkg::REG_INIT_EST:      ;
        default: ;
      endcase
    end
  end

  // Datapath control: hold off the load until a measurement is taken; restart on an initial-estimate write
  always_comb begin
    ctrl.op      = uword.op;
    ctrl.restart = 1'b0;
    if ((uword.cond == skf_pkg::C_WAIT_IN) && !in_fire) begin
      ctrl.op = skf_pkg::OP_NOP;
    end
    if (cfg_fire && (cfg_index == skf_pkg::REG_INIT_EST)) begin
      ctrl.restart = 1'b1;
    end
  end

  // Program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= skf_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Next step
  always_comb begin
    pc_next = pc + skf_pkg::PC_W'(1);
    unique case (uword.cond)
      skf_pkg::C_NEXT:     pc_next = pc + skf_pkg::PC_W'(1);
      skf_pkg::C_WAIT_IN:  pc_next = in_fire ? pc + skf_pkg::PC_W'(1) : pc;
      skf_pkg::C_LOOP:     pc_next = (cnt != '0) ? uword.target : pc + skf_pkg::PC_W'(1);
      skf_pkg::C_WAIT_OUT: pc_next = out_load ? uword.target : pc;
      skf_pkg::C_JUMP:     pc_next = uword.target;
      default:             pc_next = skf_pkg::STEP_WAIT;
    endcase
  end

  // Division loop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (uword.cnt_load) begin
      cnt <= skf_pkg::DIV_LOOP_LAST;
    end else if ((uword.cond == skf_pkg::C_LOOP) && (cnt != '0)) begin
      cnt <= cnt - skf_pkg::LOOP_CNT_W'(1);
    end
  end

  skf_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .measurement       (measurement),
    .process_noise     (process_noise),
    .measurement_noise (measurement_noise),
    .initial_estimate  (cfg_data),
    .est_value         (est_value),
    .gain              (gain)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_value <= est_value;
      gain_used      <= gain;
    end
  end

endmodule

// File: rtl/core/skf_checker.sv
// Port-level assertions for scalar_kalman_filter_top and the bind that attaches them.
// Depends on skf_pkg and the top level's ports.
`timescale 1ns / 1ps

module skf_checker #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [DATA_WIDTH-1:0]      filtered_value,
  input logic        [skf_pkg::GAIN_W-1:0] gain_used
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value) && $stable(gain_used))
    else $error("result changed while stalled");

  // Gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain_used <= skf_pkg::GAIN_ONE)
    else $error("gain above one");

  // One measurement at a time: busy right after a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second measurement taken while busy");

  // A new result never appears right after a measurement is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");

endmodule

bind scalar_kalman_filter_top skf_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_skf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .filtered_value (filtered_value),
  .gain_used      (gain_used)
);

// File: tb/tb_scalar_kalman_filter_top.sv
// Self-checking testbench for scalar_kalman_filter_top: a filter predictor in a small
// scoreboard class, valid/ready drivers and configuration sweeps. Depends on skf_pkg.
`timescale 1ns / 1ps

// One expected or observed result transaction
typedef struct packed {
  logic signed [skf_pkg::DATA_WIDTH_DEF-1:0] value;
  logic [skf_pkg::GAIN_W-1:0]                gain;
} filter_out_t;

// Tracks the filter state and the queue of estimates still owed by the block
class kalman_tracker;
  localparam int DW = skf_pkg::DATA_WIDTH_DEF;
  localparam longint unsigned GAIN_UNIT = 64'd1 << skf_pkg::GAIN_FRAC;
  localparam longint unsigned GAIN_HALF = 64'd1 << (skf_pkg::GAIN_FRAC - 1);
  localparam longint EST_MAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint EST_MIN = -EST_MAX - 1;

  logic [DW-1:0]        q_noise;
  logic [DW-1:0]        r_noise;
  logic signed [DW-1:0] estimate;
  logic [DW-1:0]        covariance;
  filter_out_t          owed_results[$];
  int                   mismatch_count;

  function new();
    mismatch_count = 0;
    reset_filter();
  endfunction

  // Power-on values: Q = 0.1, R = 1.0, estimate 0, covariance 1.0
  function void reset_filter();
    q_noise    = DW'((GAIN_UNIT + 5) / 10);
    r_noise    = DW'(GAIN_UNIT);
    estimate   = '0;
    covariance = DW'(GAIN_UNIT);
  endfunction

  function void set_register(logic [skf_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
    case (idx)
      skf_pkg::REG_PROCESS_NOISE: q_noise = data;
      skf_pkg::REG_MEAS_NOISE:    r_noise = data;
      skf_pkg::REG_INIT_EST: begin
        // restart: estimate from the register, covariance back to 1.0
        estimate   = data;
        covariance = DW'(GAIN_UNIT);
      end
      default: ;
    endcase
  endfunction

  // One filter update per accepted measurement
  function void take_measurement(logic signed [DW-1:0] meas);
    logic [DW:0]       grown;
    logic [DW-1:0]     p;
    logic [DW:0]       denom;
    longint unsigned   k;
    longint unsigned   mag;
    longint unsigned   delta;
    longint            resid;
    longint            next_est;
    filter_out_t       exp_out;
    // predict: covariance grows by Q, clamped to the unsigned range
    grown = {1'b0, covariance} + {1'b0, q_noise};
    p     = grown[DW] ? '1 : grown[DW-1:0];
    // gain in Q1.16, zero on a zero denominator
    denom = {1'b0, p} + {1'b0, r_noise};
    k     = (denom == '0) ? 64'd0 : (64'(p) << skf_pkg::GAIN_FRAC) / 64'(denom);
    // estimate update, magnitude rounded half away from zero
    resid = longint'(meas) - longint'(estimate);
    mag   = (resid < 0) ? longint'(-resid) : resid;
    delta = (mag >> skf_pkg::GAIN_FRAC) * k
          + (((mag & (GAIN_UNIT - 1)) * k + GAIN_HALF) >> skf_pkg::GAIN_FRAC);
    next_est = (resid < 0) ? longint'(estimate) - longint'(delta)
                           : longint'(estimate) + longint'(delta);
    if (next_est > EST_MAX) next_est = EST_MAX;
    if (next_est < EST_MIN) next_est = EST_MIN;
    estimate = next_est[DW-1:0];
    // covariance shrinks to (1-K)P, rounded half up
    covariance = DW'(((GAIN_UNIT - k) * 64'(p) + GAIN_HALF) >> skf_pkg::GAIN_FRAC);
    exp_out.value = estimate;
    exp_out.gain  = k[skf_pkg::GAIN_W-1:0];
    owed_results.push_back(exp_out);
  endfunction

  function void check_result(logic signed [DW-1:0] value, logic [skf_pkg::GAIN_W-1:0] gain);
    filter_out_t exp_out;
    if (owed_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: unexpected result value=%0d gain=%0d", value, gain);
      return;
    end
    exp_out = owed_results.pop_front();
    if (exp_out.value !== value || exp_out.gain !== gain) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: result mismatch: value exp %0d got %0d, gain exp %0d got %0d",
                 $signed(exp_out.value), value, exp_out.gain, gain);
    end
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  function int failures();
    return mismatch_count + owed_results.size();
  endfunction
endclass

module tb_scalar_kalman_filter_top;

  localparam int DW          = skf_pkg::DATA_WIDTH_DEF;
  localparam int SETTLE_CYC  = 32;      // a little past the input-to-result latency
  localparam int CYCLE_LIMIT = 500000;
  localparam int CHUNK_ITEMS = 100;
  localparam int NUM_CHUNKS  = 13;
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [DW-1:0]          measurement;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [DW-1:0]          filtered_value;
  logic [skf_pkg::GAIN_W-1:0]    gain_used;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0]                 cfg_data;

  kalman_tracker tracker;
  int send_idle_pct = 8;
  int recv_idle_pct = 74;
  int cycle_count   = 0;

  scalar_kalman_filter_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .measurement    (measurement),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .gain_used      (gain_used),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, check on every accepted transaction
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        tracker.check_result(filtered_value, gain_used);
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_measurement(input logic [DW-1:0] meas);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    measurement = meas;
    do @(posedge clk); while (!in_ready);
    tracker.take_measurement(meas);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [DW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
    @(negedge clk);
  endtask

  // Drain all owed results, let the block settle, then load a new setting
  task automatic apply_setting(input logic [DW-1:0] q, input logic [DW-1:0] r,
                               input logic [DW-1:0] init_est);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    write_reg(skf_pkg::REG_PROCESS_NOISE, q);
    write_reg(skf_pkg::REG_MEAS_NOISE, r);
    write_reg(REG_UNUSED, $urandom);
    write_reg(skf_pkg::REG_INIT_EST, init_est);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [DW-1:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return DW'($urandom_range(0, 65536 * 8));
      default: return DW'($urandom_range(1, 65536));
    endcase
  endfunction

  initial begin
    logic [DW-1:0] center;
    rst         = 1'b1;
    in_valid    = 1'b0;
    measurement = '0;
    cfg_valid   = 1'b0;
    cfg_index   = skf_pkg::REG_PROCESS_NOISE;
    cfg_data    = '0;
    tracker     = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset setting, full-scale and sign-boundary measurements
    send_measurement(32'h0000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'hFFFF_FFFF);
    send_measurement(32'h0000_0001);
    send_measurement(32'h0001_0000);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    // Q = R = 0: gain of one, then covariance 0 and a zero denominator
    apply_setting('0, '0, '0);
    send_measurement(32'h0001_0000);
    send_measurement(32'hFFFF_0000);
    send_measurement(32'h7FFF_FFFF);
    // both noises at full scale, covariance growth saturates
    apply_setting('1, '1, 32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h0000_0000);
    // saturated covariance with R = 0, largest residuals
    apply_setting('1, '0, 32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h0001_2345);
    apply_setting('0, '1, '0);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    apply_setting(32'd1, 32'd1, 32'hFFFF_FFFF);
    send_measurement(32'h0000_0001);
    send_measurement(32'hFFFF_FFFF);

    // Random: new setting per chunk, idling pattern changes by thirds
    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      if (chunk == 4) begin
        send_idle_pct = 74;
        recv_idle_pct = 8;
      end else if (chunk == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      center = $urandom;
      apply_setting(pick_noise(), pick_noise(), center);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        // mostly a noisy signal around a level, sometimes any value
        if ($urandom_range(0, 3) == 0)
          send_measurement($urandom);
        else
          send_measurement(center + DW'($urandom_range(0, 1 << 21)) - DW'(1 << 20));
      end
    end

    // Drain and finish
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (tracker.failures() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
